// ----- rtl/core/gauss_exp_taylor_series_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian Taylor series unit
// Both macros expect clk and arst_n in the enclosing module.
// ----------------------------------------------------------------------------
`ifndef GAUSS_EXP_TAYLOR_SERIES_UNIT_DEFINES_SVH
`define GAUSS_EXP_TAYLOR_SERIES_UNIT_DEFINES_SVH

// same-cycle implication
`define GETSU_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GETSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/getsu_pkg.sv -----
// ----------------------------------------------------------------------------
// getsu_pkg
// Shared widths, microcode encodings and control types of the series unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package getsu_pkg;

	localparam int GETSU_MAX_TERMS = 1023;

	localparam int X_W    = 16;  // Q4.12 sample
	localparam int EXP_W  = 32;  // Q0.32 result
	localparam int TC_W   = 10;  // term count register
	localparam int H_W    = 22;  // x*x/2 in Q6.16, at most 32.0
	localparam int TERM_W = 64;  // Q48.16 term and sum
	localparam int HALF_W = TERM_W / 2;
	localparam int PROD_W = HALF_W + H_W;

	// term division: quotient bits per cycle
	localparam int DIV_BITS   = 8;
	localparam int DIV_CYCLES = TERM_W / DIV_BITS;

	// reciprocal: 33 quotient bits, one per cycle
	localparam int RCP_STEPS = EXP_W + 1;
	localparam int CNT_W     = $clog2(RCP_STEPS);

	localparam logic [TC_W-1:0]   TC_RESET     = 10'd128;
	localparam logic [TERM_W-1:0] FIX_ONE      = 64'h0000_0000_0001_0000;
	// 2^48 >> 33: top of the reciprocal dividend
	localparam logic [TERM_W-1:0] RCP_REM_INIT = 64'h0000_0000_0000_8000;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// datapath operations
	typedef logic [3:0] op_t;
	localparam op_t OP_NOP      = 4'd0;
	localparam op_t OP_LOAD     = 4'd1;
	localparam op_t OP_INIT     = 4'd2;
	localparam op_t OP_MUL_LO   = 4'd3;
	localparam op_t OP_MUL_HI   = 4'd4;
	localparam op_t OP_DIV_LD   = 4'd5;
	localparam op_t OP_DIV_STEP = 4'd6;
	localparam op_t OP_ACC      = 4'd7;
	localparam op_t OP_RCP_LD   = 4'd8;
	localparam op_t OP_RCP_STEP = 4'd9;
	localparam op_t OP_FIN      = 4'd10;
	localparam op_t OP_ERR      = 4'd11;

	// jump conditions
	typedef logic [2:0] cond_t;
	localparam cond_t COND_NONE    = 3'd0;
	localparam cond_t COND_ALWAYS  = 3'd1;
	localparam cond_t COND_NO_IN   = 3'd2;
	localparam cond_t COND_TC_ZERO = 3'd3;
	localparam cond_t COND_CNT_NZ  = 3'd4;
	localparam cond_t COND_MORE    = 3'd5;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctl_t;

	typedef struct packed {
		logic cnt_nz;  // repeat counter not yet exhausted
		logic more;    // another series term is due
	} dp_flags_t;

endpackage

// ----- rtl/core/getsu_datapath.sv -----
// ----------------------------------------------------------------------------
// getsu_datapath
// Registers, multiplier and dividers driven by the microcode op.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gauss_exp_taylor_series_unit_defines.svh"

module getsu_datapath
	import getsu_pkg::*;
#(
	parameter int MAX_TERMS = GETSU_MAX_TERMS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  op_t                     op,
	input  logic signed [X_W-1:0]   sample_x,
	input  logic [TC_W-1:0]         term_count,
	output dp_flags_t               flags,
	output logic [EXP_W-1:0]        rcp_value
);

	localparam int IW    = $clog2(MAX_TERMS + 1);
	localparam int DVD_W = PROD_W + HALF_W;
	localparam int CMP_W = 17;
	localparam int OVF_W = DVD_W - TERM_W;

	logic [X_W-1:0]    mag_q;
	logic [H_W-1:0]    h_q;
	logic [TERM_W-1:0] term_q, sum_q;
	logic [IW-1:0]     i_q, n_q;
	logic [PROD_W-1:0] prod_lo_q, prod_hi_q;
	logic [IW-1:0]     div_rem_q;
	logic [TERM_W-1:0] div_sh_q;  // dividend bits out, quotient bits in
	logic              ovf_q;     // quotient of this term does not fit 64 bits
	logic [TERM_W-1:0] rcp_rem_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [X_W-1:0]    x_raw, mag_d;
	logic [2*X_W-1:0]  sq;
	logic [PROD_W-1:0] mul_lo, mul_hi;
	logic [DVD_W-1:0]  dvd;
	logic [IW-1:0]     n_d;
	logic              ovf_d;
	logic [IW-1:0]     div_rem_d;
	logic [TERM_W-1:0] div_sh_d;
	logic [TERM_W-1:0] term_d;
	logic [TERM_W:0]   sum_add;
	logic [TERM_W:0]   rcp_t, rcp_diff;
	logic              rcp_ge;

	assign x_raw  = sample_x;
	assign mag_d  = x_raw[X_W-1] ? (~x_raw + X_W'(1)) : x_raw;
	assign sq     = mag_q * mag_q;
	assign mul_lo = term_q[HALF_W-1:0] * h_q;
	assign mul_hi = term_q[TERM_W-1:HALF_W] * h_q;
	assign dvd    = {prod_hi_q, {HALF_W{1'b0}}} + DVD_W'(prod_lo_q);

	// quotient reaches 2^64 when the bits above 64 are not below the index
	assign ovf_d  = (dvd[DVD_W-1:TERM_W] >= OVF_W'(i_q));

	// term and sum saturate at 2^64-1
	assign term_d  = ovf_q ? {TERM_W{1'b1}} : div_sh_q;
	assign sum_add = {1'b0, sum_q} + {1'b0, term_d};

	assign n_d = ({{(CMP_W-TC_W){1'b0}}, term_count} > CMP_W'(MAX_TERMS)) ?
		IW'(MAX_TERMS) : IW'(term_count);

	// DIV_BITS restoring steps on the narrow remainder
	always_comb begin
		logic [IW:0]       t;
		logic [IW-1:0]     r;
		logic [TERM_W-1:0] s;
		r = div_rem_q;
		s = div_sh_q;
		for (int k = 0; k < DIV_BITS; k++) begin
			t = {r, s[TERM_W-1]};
			s = {s[TERM_W-2:0], 1'b0};
			if (t >= {1'b0, i_q}) begin
				t    = t - {1'b0, i_q};
				s[0] = 1'b1;
			end
			r = t[IW-1:0];
		end
		div_rem_d = r;
		div_sh_d  = s;
	end

	// one reciprocal quotient bit; shifted-in dividend bits are zero
	assign rcp_t    = {rcp_rem_q, 1'b0};
	assign rcp_diff = rcp_t - {1'b0, sum_q};
	assign rcp_ge   = (rcp_t >= {1'b0, sum_q});

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				mag_q <= mag_d;
			end
			OP_INIT: begin
				h_q    <= sq[9 +: H_W];
				term_q <= FIX_ONE;
				sum_q  <= FIX_ONE;
				i_q    <= IW'(1);
				n_q    <= n_d;
			end
			OP_MUL_LO: begin
				prod_lo_q <= mul_lo;
			end
			OP_MUL_HI: begin
				prod_hi_q <= mul_hi;
			end
			OP_DIV_LD: begin
				ovf_q     <= ovf_d;
				div_rem_q <= ovf_d ? '0 : dvd[TERM_W +: IW];
				div_sh_q  <= dvd[TERM_W-1:0];
			end
			OP_DIV_STEP: begin
				div_rem_q <= div_rem_d;
				div_sh_q  <= div_sh_d;
			end
			OP_ACC: begin
				term_q <= term_d;
				sum_q  <= sum_add[TERM_W] ? {TERM_W{1'b1}} : sum_add[TERM_W-1:0];
				i_q    <= i_q + IW'(1);
			end
			OP_RCP_LD: begin
				rcp_rem_q <= RCP_REM_INIT;
				div_sh_q  <= '0;
			end
			OP_RCP_STEP: begin
				rcp_rem_q <= rcp_ge ? rcp_diff[TERM_W-1:0] : rcp_t[TERM_W-1:0];
				div_sh_q  <= {div_sh_q[TERM_W-2:0], rcp_ge};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (op) inside
				OP_DIV_LD:                 cnt_q <= CNT_W'(DIV_CYCLES - 1);
				OP_RCP_LD:                 cnt_q <= CNT_W'(RCP_STEPS - 1);
				OP_DIV_STEP, OP_RCP_STEP:  cnt_q <= cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	assign flags.cnt_nz = (cnt_q != '0);
	assign flags.more   = (i_q != n_q) && (term_d != '0);

	// quotient of 2^48 / sum saturates at 2^32 - 1 when the sum is exactly one
	assign rcp_value = div_sh_q[EXP_W] ? {EXP_W{1'b1}} : div_sh_q[EXP_W-1:0];

	`GETSU_ASSERT(a_idx_range, op == OP_ACC, (i_q != '0) && (i_q <= n_q), "term index out of range")
	`GETSU_ASSERT_NEXT(a_div_rem_init, op == OP_DIV_LD, div_rem_q < i_q, "term remainder not below index")
	`GETSU_ASSERT(a_rcp_rem, op == OP_RCP_STEP, rcp_rem_q < sum_q, "reciprocal remainder not below sum")

endmodule

// ----- rtl/core/gauss_exp_taylor_series_unit.sv -----
// ----------------------------------------------------------------------------
// gauss_exp_taylor_series_unit
// Gaussian kernel exp(-x*x/2) from a Taylor series and a reciprocal.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid / sample_ready carry one word, sample_x,
//   signed Q4.12. Result channel: result_valid / result_ready carry
//   exp_value (unsigned Q0.32) and status (0 ok, 1 term count zero).
//   APB register 0 at byte 0: term_count, 10 bits, reset 128.
//   One sample is in work at a time; sample_ready is high only while the
//   sequencer sits in its idle step.
//   The unit sums k terms, where k is min(term_count, MAX_TERMS), fewer
//   once a term truncates to zero. Each term takes two 32x22 multiplies,
//   one add, an 8-bit-per-cycle divider and one accumulate; the final
//   reciprocal is a bit-serial divide of 33 quotient bits. A zero term
//   count skips the series and answers from the error step. The next
//   sample may be accepted in the cycle after the result is loaded into
//   the output register.
//   If the receiver stalls, the result stays in the output register and the
//   sequencer holds at its final step until the register frees.
//   Reset clears the sequencer to idle, drops result_valid, loads 128.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gauss_exp_taylor_series_unit_defines.svh"

module gauss_exp_taylor_series_unit
	import getsu_pkg::*;
#(
	parameter int MAX_TERMS = GETSU_MAX_TERMS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// sample words
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic signed [X_W-1:0] sample_x,
	// result words
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [EXP_W-1:0]      exp_value,
	output logic                  status
);

	localparam logic REG_TERM_COUNT = 1'b0;

	// microcode addresses
	localparam pc_t PC_IDLE   = 4'd0;
	localparam pc_t PC_INIT   = 4'd1;
	localparam pc_t PC_MUL_LO = 4'd2;
	localparam pc_t PC_MUL_HI = 4'd3;
	localparam pc_t PC_DIV_LD = 4'd4;
	localparam pc_t PC_DIV    = 4'd5;
	localparam pc_t PC_ACC    = 4'd6;
	localparam pc_t PC_RCP_LD = 4'd7;
	localparam pc_t PC_RCP    = 4'd8;
	localparam pc_t PC_FIN    = 4'd9;
	localparam pc_t PC_ERR    = 4'd10;

	// program: one control word per step
	function automatic ctl_t ucode(input pc_t pc);
		ctl_t c;
		c = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE};
		unique case (pc)
			PC_IDLE:   c = '{op: OP_LOAD,     cond: COND_NO_IN,   target: PC_IDLE};
			PC_INIT:   c = '{op: OP_INIT,     cond: COND_TC_ZERO, target: PC_ERR};
			PC_MUL_LO: c = '{op: OP_MUL_LO,   cond: COND_NONE,    target: PC_IDLE};
			PC_MUL_HI: c = '{op: OP_MUL_HI,   cond: COND_NONE,    target: PC_IDLE};
			PC_DIV_LD: c = '{op: OP_DIV_LD,   cond: COND_NONE,    target: PC_IDLE};
			PC_DIV:    c = '{op: OP_DIV_STEP, cond: COND_CNT_NZ,  target: PC_DIV};
			PC_ACC:    c = '{op: OP_ACC,      cond: COND_MORE,    target: PC_MUL_LO};
			PC_RCP_LD: c = '{op: OP_RCP_LD,   cond: COND_NONE,    target: PC_IDLE};
			PC_RCP:    c = '{op: OP_RCP_STEP, cond: COND_CNT_NZ,  target: PC_RCP};
			PC_FIN:    c = '{op: OP_FIN,      cond: COND_ALWAYS,  target: PC_IDLE};
			PC_ERR:    c = '{op: OP_ERR,      cond: COND_ALWAYS,  target: PC_IDLE};
			default: ;
		endcase
		return c;
	endfunction

	logic [TC_W-1:0]  term_count_q;
	pc_t              pc_q;
	logic             result_valid_q;
	logic [EXP_W-1:0] exp_value_q;
	logic             status_q;

	ctl_t             ctl;
	dp_flags_t        flags;
	logic [EXP_W-1:0] rcp_value;
	logic             take, emit, hold, cfg_wr;
	pc_t              pc_d;

	// --- configuration port ---
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TERM_COUNT);
	assign prdata = (paddr[2] == REG_TERM_COUNT) ? {{(32-TC_W){1'b0}}, term_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TC_RESET;
		end else if (cfg_wr) begin
			term_count_q <= pwdata[TC_W-1:0];
		end
	end

	// --- sequencer ---
	assign ctl = ucode(pc_q);

	always_comb begin
		case (ctl.cond)
			COND_ALWAYS:  take = 1'b1;
			COND_NO_IN:   take = !sample_valid;
			COND_TC_ZERO: take = (term_count_q == '0);
			COND_CNT_NZ:  take = flags.cnt_nz;
			COND_MORE:    take = flags.more;
			default:      take = 1'b0;
		endcase
	end

	// final steps wait for a free output register
	assign emit = (ctl.op == OP_FIN) || (ctl.op == OP_ERR);
	assign hold = emit && result_valid_q && !result_ready;
	assign pc_d = hold ? pc_q : (take ? ctl.target : pc_t'(pc_q + 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	// idle step loads the sample register each cycle, so the accepted word sticks
	assign sample_ready = (pc_q == PC_IDLE);

	getsu_datapath #(
		.MAX_TERMS (MAX_TERMS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (ctl.op),
		.sample_x   (sample_x),
		.term_count (term_count_q),
		.flags      (flags),
		.rcp_value  (rcp_value)
	);

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit && !hold) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !hold) begin
			exp_value_q <= (ctl.op == OP_FIN) ? rcp_value : '0;
			status_q    <= (ctl.op == OP_ERR) ? STATUS_ERR : STATUS_OK;
		end
	end

	assign result_valid = result_valid_q;
	assign exp_value    = exp_value_q;
	assign status       = status_q;

	`GETSU_ASSERT(a_err_zero_value, result_valid && (status == STATUS_ERR), exp_value == '0, "error result carries a value")
	`GETSU_ASSERT(a_err_only_tc_zero, pc_q == PC_ERR, term_count_q == '0, "error step with nonzero term count")
	`GETSU_ASSERT_NEXT(a_busy_after_accept, sample_valid && sample_ready, !sample_ready && (pc_q == PC_INIT), "sequencer did not start")

endmodule

// ----- dv/tb_gauss_exp_taylor_series_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gauss_exp_taylor_series_unit
// Self-checking bench for the Gaussian Taylor series unit. A short directed
// table covers the sample extremes and the zero term count error, and sums
// that collapse to exactly one. It also covers term counts 1, 2, 128 and
// 1023. Random phases follow, each with its own term count, mostly small.
// Result words are compared with typed answers or with a predictor that
// models the series bit for bit.
// ----------------------------------------------------------------------------

module tb_gauss_exp_taylor_series_unit
	import getsu_pkg::*;
();

	// register map: term_count is register 0 at byte 0
	localparam logic [2:0] REG_TERM_COUNT = 3'd0;

	localparam int     RANDOM_ITEMS = 1750;
	localparam longint CYCLE_LIMIT  = 64'd100_000_000;
	localparam int     LONG_STALL   = 3000;  // receiver hold-off, in cycles
	localparam int     TAIL_CYCLES  = 200;   // quiet time after the last result

	typedef struct packed {
		logic [EXP_W-1:0] exp_value;
		logic             status;
	} exp_result_t;

	// directed row: term count in force, sample, and optional typed answer
	typedef struct packed {
		logic [TC_W-1:0]       tc;
		logic signed [X_W-1:0] x;
		logic                  known;
		logic [EXP_W-1:0]      exp_value;
		logic                  status;
	} dir_row_t;

	localparam int N_DIR = 20;
	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		// reset term count; tiny |x| gives h = 0, sum 1.0, saturated result
		'{10'd128, 16'sh0000, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
		'{10'd128, 16'sd22,   1'b1, 32'hFFFF_FFFF, STATUS_OK},
		'{10'd128, -16'sd22,  1'b1, 32'hFFFF_FFFF, STATUS_OK},
		'{10'd128, 16'sd23,   1'b0, 32'h0,         STATUS_OK},
		'{10'd128, 16'sh1000, 1'b0, 32'h0,         STATUS_OK},
		'{10'd128, -16'sh1000, 1'b0, 32'h0,        STATUS_OK},
		'{10'd128, 16'sh7FFF, 1'b0, 32'h0,         STATUS_OK},
		'{10'd128, 16'sh8000, 1'b0, 32'h0,         STATUS_OK},
		'{10'd128, 16'sh0100, 1'b0, 32'h0,         STATUS_OK},
		// zero term count: error word regardless of x
		'{10'd0,   16'sh0000, 1'b1, 32'h0,         STATUS_ERR},
		'{10'd0,   16'sh7FFF, 1'b1, 32'h0,         STATUS_ERR},
		'{10'd0,   16'sh8000, 1'b1, 32'h0,         STATUS_ERR},
		// single term
		'{10'd1,   16'sh8000, 1'b0, 32'h0,         STATUS_OK},
		'{10'd1,   16'sh5555, 1'b0, 32'h0,         STATUS_OK},
		'{10'd1,   16'sh0000, 1'b1, 32'hFFFF_FFFF, STATUS_OK},
		// longest series; large x saturates the sum
		'{10'd1023, 16'sh8000, 1'b0, 32'h0,        STATUS_OK},
		'{10'd1023, 16'shAAAA, 1'b0, 32'h0,        STATUS_OK},
		'{10'd1023, 16'sd23,   1'b0, 32'h0,        STATUS_OK},
		'{10'd2,   16'sh1234, 1'b0, 32'h0,         STATUS_OK},
		'{10'd2,   -16'sd1,   1'b1, 32'hFFFF_FFFF, STATUS_OK}
	};

	// DUT ports; the bench drives its inputs known from time zero
	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [2:0]            paddr        = REG_TERM_COUNT;
	logic [31:0]           pwdata       = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  sample_valid = 1'b0;
	logic                  sample_ready;
	logic signed [X_W-1:0] sample_x     = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b1;
	logic [EXP_W-1:0]      exp_value;
	logic                  status;

	// bench state
	exp_result_t     pending_results[$];   // expected words, oldest first
	logic [TC_W-1:0] cur_term_count = TC_RESET;
	int              errors          = 0;
	int              samples_sent    = 0;
	int              results_checked = 0;
	int              error_words     = 0;
	int              settings_used   = 0;
	bit              long_stall_done = 1'b0;
	longint          cycle_count     = 0;

	gauss_exp_taylor_series_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_x    (sample_x),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.exp_value   (exp_value),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Predictor. h = x*x >> 9 is used as a plain integer multiplier on the
	// Q48.16 term, each term floor(term*h/i), sums and terms saturate at
	// 2^64-1, and the answer is floor(2^48/sum) clipped to 32 bits.
	// ------------------------------------------------------------------------
	function automatic exp_result_t gauss_exp_predict(logic [X_W-1:0] x, logic [TC_W-1:0] tc);
		exp_result_t      res;
		logic [63:0]      mag;
		logic [63:0]      h;
		logic [63:0]      term;
		logic [63:0]      sum;
		logic [63:0]      quot;
		logic [127:0]     wide;
		int               n;
		mag = x[X_W-1] ? (64'h1_0000 - {48'b0, x}) : {48'b0, x};
		h   = (mag * mag) >> 9;
		if (tc == '0) begin
			res.exp_value = '0;
			res.status    = STATUS_ERR;
			return res;
		end
		n    = (int'(tc) > GETSU_MAX_TERMS) ? GETSU_MAX_TERMS : int'(tc);
		term = FIX_ONE;
		sum  = FIX_ONE;
		// series stops early once a term truncates to zero
		for (int i = 1; i <= n && term != '0; i++) begin
			wide = ({64'b0, term} * {64'b0, h}) / 128'(i);
			term = (wide[127:64] != '0) ? '1 : wide[63:0];
			sum  = (sum > ~term) ? '1 : sum + term;
		end
		quot          = (64'h1 << 48) / sum;
		res.exp_value = (quot > 64'hFFFF_FFFF) ? '1 : quot[EXP_W-1:0];
		res.status    = STATUS_OK;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Result checker: every accepted word against the oldest expectation.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		exp_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected: exp_value %h status %0d",
					exp_value, status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (exp_value !== want.exp_value) begin
					$error("exp_value mismatch: expected %h, got %h", want.exp_value, exp_value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (want.status == STATUS_ERR)
					error_words++;
				results_checked++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver: mostly ready, short and occasional long stalls, clean runs.
	// Once, while a result waits and the sender is offering the next word,
	// it holds ready low for the LONG_STALL hold-off so the unit backs up to its input.
	// ------------------------------------------------------------------------
	initial begin
		int hold;
		int run;
		int roll;
		logic rdy;
		hold = 0;
		run  = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_stall_done && results_checked >= 150 && result_valid && sample_valid) begin
				long_stall_done = 1'b1;
				hold = LONG_STALL;
				run  = 0;
			end
			if (hold > 0) begin
				hold--;
				rdy = 1'b0;
			end else if (run > 0) begin
				run--;
				rdy = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				rdy  = 1'b1;
				if (roll < 60) begin
					rdy = 1'b1;
				end else if (roll < 90) begin
					rdy  = 1'b0;
					hold = $urandom_range(0, 2);
				end else if (roll < 97) begin
					rdy  = 1'b0;
					hold = $urandom_range(20, 60);
				end else begin
					run = $urandom_range(100, 400);
				end
			end
			result_ready <= rdy;
		end
	end

	// sender gap: mostly none or short, a few long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// sample mix: full range, mid range and near zero
	function automatic logic [X_W-1:0] pick_sample();
		int roll;
		logic [X_W-1:0] v;
		roll = $urandom_range(0, 9);
		v    = X_W'($urandom_range(0, 65535));
		if (roll < 3)
			v = X_W'($signed($urandom_range(0, 4095)) - 2048);
		else if (roll < 5)
			v = X_W'($signed($urandom_range(0, 127)) - 64);
		return v;
	endfunction

	// Offer one sample word after an optional gap; valid stays up until taken.
	task automatic offer_sample(input logic [X_W-1:0] x, input int gap, input exp_result_t want);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample_x     <= x;
		do @(posedge clk); while (!sample_ready);
		pending_results.push_back(want);
		samples_sent++;
	endtask

	// One APB transfer to the term count register: setup, then access.
	task automatic apb_xfer(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= REG_TERM_COUNT;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata   = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Let the unit go idle, write a new term count and read it back.
	task automatic set_term_count(input logic [TC_W-1:0] tc);
		logic [31:0] rd;
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		apb_xfer(1'b1, 32'(tc), rd);
		apb_xfer(1'b0, '0, rd);
		if (rd[TC_W-1:0] !== tc) begin
			$error("term_count readback mismatch: expected %0d, got %0d", tc, rd[TC_W-1:0]);
			errors++;
		end
		cur_term_count = tc;
		settings_used++;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [31:0] rd;
		exp_result_t want;
		int          random_sent;
		int          count;
		int          roll;
		bit          no_idle;
		logic [TC_W-1:0] tc;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the register
		apb_xfer(1'b0, '0, rd);
		if (rd[TC_W-1:0] !== TC_RESET) begin
			$error("term_count after reset: expected %0d, got %0d", TC_RESET, rd[TC_W-1:0]);
			errors++;
		end
		settings_used++;

		// directed table; a change of term count drains the unit first
		for (int r = 0; r < N_DIR; r++) begin
			if (DIR_ROWS[r].tc != cur_term_count)
				set_term_count(DIR_ROWS[r].tc);
			if (DIR_ROWS[r].known) begin
				want.exp_value = DIR_ROWS[r].exp_value;
				want.status    = DIR_ROWS[r].status;
			end else begin
				want = gauss_exp_predict(DIR_ROWS[r].x, cur_term_count);
			end
			offer_sample(DIR_ROWS[r].x, pick_gap(), want);
		end

		// random phases: mostly short series, a few long ones, some errors
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				tc    = '0;
				count = 40;
			end else if (roll < 12) begin
				tc    = TC_W'(GETSU_MAX_TERMS);
				count = 4;
			end else if (roll < 22) begin
				tc    = TC_W'($urandom_range(17, 200));
				count = 20;
			end else begin
				tc    = TC_W'($urandom_range(1, 16));
				count = 150;
			end
			if (count > RANDOM_ITEMS - random_sent)
				count = RANDOM_ITEMS - random_sent;
			no_idle = ($urandom_range(0, 3) == 0);
			set_term_count(tc);
			for (int j = 0; j < count; j++) begin
				logic [X_W-1:0] x;
				x = pick_sample();
				offer_sample(x, no_idle ? 0 : pick_gap(), gauss_exp_predict(x, cur_term_count));
			end
			random_sent += count;
		end

		// drain, then watch for stray words
		sample_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d samples sent, %0d result words checked (%0d zero-count errors)",
			samples_sent, results_checked, error_words);
		$display("run: %0d term count settings, receiver long hold-off %s",
			settings_used, long_stall_done ? "done" : "not reached");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
